/* design/nearest_palette_color_search_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette color search unit
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define NPCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npcs check failed");

// next-cycle implication
`define NPCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npcs check failed");

`endif

/* design/npcs_pkg.sv */
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared widths, constants and control types of the palette search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npcs_pkg;

    localparam int PALETTE_ENTRIES_DEFAULT = 256;
    localparam int INDEX_W = 8;
    localparam int COLOR_W = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic write_en;
        logic load_query;
        logic scan_en;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } dp_stat_t;

endpackage

/* design/npcs_ctrl.sv */
// ----------------------------------------------------------------------------
// npcs_ctrl
// Sequencer: accepts commands, steps the scan, drains the pipe, strobes done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 mode,
    input  npcs_pkg::dp_stat_t   stat,
    output npcs_pkg::ctrl_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import npcs_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_DRAIN_A = 3'd2;
    localparam logic [2:0] ST_DRAIN_B = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_FINISH);

    assign cmd.write_en   = accept && (mode == MODE_WRITE);
    assign cmd.load_query = accept && (mode == MODE_QUERY);
    assign cmd.scan_en    = (state_reg == ST_SCAN);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A: state_next = ST_DRAIN_B;
            ST_DRAIN_B: state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/npcs_dp.sv */
// ----------------------------------------------------------------------------
// npcs_dp
// Palette memory, scan address, distance pipe and running minimum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npcs_dp #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  npcs_pkg::ctrl_cmd_t            cmd,
    input  logic [npcs_pkg::INDEX_W-1:0]   entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]   red,
    input  logic [npcs_pkg::COLOR_W-1:0]   green,
    input  logic [npcs_pkg::COLOR_W-1:0]   blue,
    output npcs_pkg::dp_stat_t             stat,
    output logic [npcs_pkg::INDEX_W-1:0]   nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]    nearest_distance
);
    import npcs_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int ENT_W = 3 * COLOR_W;

    // palette storage; entries never written read as black
    logic [ENT_W-1:0]           palette_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] entry_valid_reg;
    logic                       wr_in_range;
    logic [IDX_W-1:0]           wr_addr;

    // query color
    logic [COLOR_W-1:0] q_red_reg;
    logic [COLOR_W-1:0] q_green_reg;
    logic [COLOR_W-1:0] q_blue_reg;

    // scan address
    logic [IDX_W-1:0] scan_addr_reg;
    logic [IDX_W-1:0] scan_addr_next;

    // stage 1: registered read
    logic             s1_v_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [ENT_W-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [ENT_W-1:0] s1_entry;

    // stage 2: squared component differences
    logic             s2_v_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [SQ_W-1:0]  sq_r_reg;
    logic [SQ_W-1:0]  sq_g_reg;
    logic [SQ_W-1:0]  sq_b_reg;
    logic [COLOR_W-1:0] d_r;
    logic [COLOR_W-1:0] d_g;
    logic [COLOR_W-1:0] d_b;

    // stage 3: running minimum
    logic [DIST_W-1:0] cand_dist;
    logic [DIST_W-1:0] best_dist_reg;
    logic [DIST_W-1:0] best_dist_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;

    function automatic logic [COLOR_W-1:0] abs_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    assign wr_in_range = ({1'b0, entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
    assign wr_addr     = entry_index[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.write_en && wr_in_range)
        begin
            palette_mem[wr_addr] <= {red, green, blue};
        end
        rd_data_reg <= palette_mem[scan_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (cmd.write_en && wr_in_range)
        begin
            entry_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_red_reg   <= red;
            q_green_reg <= green;
            q_blue_reg  <= blue;
        end
    end

    assign stat.scan_last = (scan_addr_reg == IDX_W'(PALETTE_ENTRIES - 1));

    always_comb
    begin
        scan_addr_next = scan_addr_reg;
        if (cmd.load_query)
        begin
            scan_addr_next = '0;
        end
        else if (cmd.scan_en)
        begin
            scan_addr_next = scan_addr_reg + 1'b1;
        end
    end

    assign s1_entry = rd_valid_reg ? rd_data_reg : '0;
    assign d_r = abs_diff(s1_entry[3*COLOR_W-1:2*COLOR_W], q_red_reg);
    assign d_g = abs_diff(s1_entry[2*COLOR_W-1:COLOR_W], q_green_reg);
    assign d_b = abs_diff(s1_entry[COLOR_W-1:0], q_blue_reg);

    assign cand_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    // strict less-than keeps the lower index on ties
    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (cmd.load_query)
        begin
            best_dist_next = '1;
            best_idx_next  = '0;
        end
        else if (s2_v_reg && (cand_dist < best_dist_reg))
        begin
            best_dist_next = cand_dist;
            best_idx_next  = s2_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
        end
        else
        begin
            scan_addr_reg <= scan_addr_next;
            s1_v_reg      <= cmd.scan_en;
            s2_v_reg      <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg  <= entry_valid_reg[scan_addr_reg];
        s1_idx_reg    <= scan_addr_reg;
        s2_idx_reg    <= s1_idx_reg;
        sq_r_reg      <= SQ_W'(d_r) * SQ_W'(d_r);
        sq_g_reg      <= SQ_W'(d_g) * SQ_W'(d_g);
        sq_b_reg      <= SQ_W'(d_b) * SQ_W'(d_b);
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
    end

    assign nearest_index    = INDEX_W'(best_idx_reg);
    assign nearest_distance = best_dist_reg;

endmodule

/* design/nearest_palette_color_search_unit.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit
// Palette of RGB entries with a nearest-color query (squared Euclidean).
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload
//  --------  ------------------  ---------------------------------------
//  command   start, busy         mode, entry_index, red, green, blue
//  result    done (1-cycle)      nearest_index, nearest_distance
//
//  A beat on the command channel is taken at a clock edge with start high
//  and busy low. A write beat completes at that edge; busy stays low and
//  the next beat may follow in the very next cycle.
//  A query beat holds busy through the scan: one palette entry is read per
//  cycle from the single read port, then the DRAIN_A and DRAIN_B states
//  drain the read and square stages, then done pulses for one cycle.
//  Reset clears the per-entry valid bits at once, so every entry reads as
//  black with no clearing pass. The receiver cannot stall: done is a
//  one-cycle strobe and the result ports hold the answer during it.
//
`timescale 1ns / 1ps

module nearest_palette_color_search_unit #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [npcs_pkg::INDEX_W-1:0]   entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]   red,
    input  logic [npcs_pkg::COLOR_W-1:0]   green,
    input  logic [npcs_pkg::COLOR_W-1:0]   blue,
    output logic                           done,
    output logic [npcs_pkg::INDEX_W-1:0]   nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]    nearest_distance
);
    import npcs_pkg::*;

    ctrl_cmd_t cmd;   // write, query load, scan step
    dp_stat_t  stat;  // last scan address reached

    // sequencer
    npcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // palette memory and distance pipe; the best index and distance
    // registers drive the result ports directly
    npcs_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .entry_index      (entry_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .stat             (stat),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance)
    );

endmodule

/* design/npcs_checker.sv */
// ----------------------------------------------------------------------------
// npcs_checker
// Port-level checks of the palette search unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_palette_color_search_unit_defines.svh"

module npcs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           mode,
    input logic [npcs_pkg::INDEX_W-1:0]   entry_index,
    input logic [npcs_pkg::COLOR_W-1:0]   red,
    input logic [npcs_pkg::COLOR_W-1:0]   green,
    input logic [npcs_pkg::COLOR_W-1:0]   blue,
    input logic                           done,
    input logic [npcs_pkg::INDEX_W-1:0]   nearest_index,
    input logic [npcs_pkg::DIST_W-1:0]    nearest_distance
);
    import npcs_pkg::*;

    logic wr_beat;
    logic q_beat;

    assign wr_beat = start && !busy && (mode == MODE_WRITE);
    assign q_beat  = start && !busy && (mode == MODE_QUERY);

    // a write completes in its own cycle
    `NPCS_ASSERT_NXT(a_write_no_busy, wr_beat, !busy && !done)
    // a query starts a scan
    `NPCS_ASSERT_NXT(a_query_busy, q_beat, busy && !done)
    // the result strobe ends the busy period and lasts one cycle
    `NPCS_ASSERT_NXT(a_done_single, done, !done && !busy)
    // results only during busy, and in range
    `NPCS_ASSERT_IMP(a_done_range, done, busy && (nearest_distance <= DIST_MAX))

endmodule

bind nearest_palette_color_search_unit npcs_checker u_npcs_checker (.*);

/* tb/nearest_palette_color_search_unit_test.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit_test
// Self-checking bench: palette writes and nearest-color queries go to the
// unit, and a shadow palette in the bench predicts every index and distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_palette_color_search_unit_test;

    import npcs_pkg::*;

    localparam int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT;
    localparam int MAX_REPORTS     = 10;

    // one command beat plus the idle cycles the driver spends before raising start
    typedef struct {
        logic                 mode;
        logic [INDEX_W-1:0]   idx;
        logic [COLOR_W-1:0]   r;
        logic [COLOR_W-1:0]   g;
        logic [COLOR_W-1:0]   b;
        int unsigned          gap;
    } palette_cmd_t;

    typedef struct {
        logic [INDEX_W-1:0]   index;
        logic [DIST_W-1:0]    distance;
    } color_match_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 mode = MODE_WRITE;
    logic [INDEX_W-1:0]   entry_index = '0;
    logic [COLOR_W-1:0]   red = '0;
    logic [COLOR_W-1:0]   green = '0;
    logic [COLOR_W-1:0]   blue = '0;
    logic                 done;
    logic [INDEX_W-1:0]   nearest_index;
    logic [DIST_W-1:0]    nearest_distance;

    nearest_palette_color_search_unit #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .entry_index      (entry_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .done             (done),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    palette_cmd_t         pending_cmds[$];     // beats not yet handed to the driver
    color_match_t         awaited_matches[$];  // predicted answers, oldest first
    logic [23:0]          palette_shadow[PALETTE_ENTRIES];  // {r,g,b}, tracks the unit
    logic [23:0]          plan_palette[256];   // generator's view, for picking hit colors

    int unsigned          beats_total;
    int unsigned          beats_taken;
    int unsigned          writes_taken;
    int unsigned          queries_taken;
    int unsigned          results_seen;
    int unsigned          exact_hits;
    int unsigned          mismatches;
    int unsigned          calm_left;           // beats left in a no-idle stretch

    palette_cmd_t         on_port;
    palette_cmd_t         next_cmd;
    bit                   holding;
    int unsigned          hold_off;
    color_match_t         oldest;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Linear scan in index order; strict less-than keeps the lowest index on ties.
    function automatic color_match_t nearest_entry(logic [7:0] qr, logic [7:0] qg,
                                                   logic [7:0] qb);
        color_match_t best;
        int           dr;
        int           dg;
        int           db;
        int           d2;
        int           best_dist;
        best_dist = -1;
        best.index = '0;
        best.distance = '0;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            dr = int'(palette_shadow[i][23:16]) - int'(qr);
            dg = int'(palette_shadow[i][15:8]) - int'(qg);
            db = int'(palette_shadow[i][7:0]) - int'(qb);
            d2 = dr * dr + dg * dg + db * db;
            if (best_dist < 0 || d2 < best_dist)
            begin
                best_dist = d2;
                best.index = INDEX_W'(i);
                best.distance = DIST_W'(d2);
            end
        end
        return best;
    endfunction

    // Called on every accepted beat, in acceptance order.
    task automatic apply_beat(palette_cmd_t cmd);
        if (cmd.mode == MODE_WRITE)
        begin
            writes_taken++;
            // out-of-range writes are dropped by the unit
            if (int'(cmd.idx) < PALETTE_ENTRIES)
                palette_shadow[cmd.idx] = {cmd.r, cmd.g, cmd.b};
        end
        else
        begin
            queries_taken++;
            awaited_matches.push_back(nearest_entry(cmd.r, cmd.g, cmd.b));
        end
    endtask

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mostly back-to-back or short gaps, a few long ones; long gaps can
    // outlast a whole query so start also rises at every point after busy drops.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 320);
    endfunction

    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic logic [7:0] rail();
        return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endfunction

    task automatic queue_cmd(logic m, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
        palette_cmd_t cmd;
        cmd.mode = m;
        cmd.idx = idx;
        cmd.r = r;
        cmd.g = g;
        cmd.b = b;
        if (calm_left == 0 && $urandom_range(0, 99) < 3)
            calm_left = $urandom_range(20, 60);
        if (calm_left != 0)
        begin
            cmd.gap = 0;
            calm_left--;
        end
        else
            cmd.gap = pick_gap();
        if (m == MODE_WRITE)
            plan_palette[idx] = {r, g, b};
        pending_cmds.push_back(cmd);
        beats_total++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: one beat at a time from pending_cmds. start is held through busy
    // and only one nonblocking update of each input lands per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            holding = 1'b0;
            hold_off = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_beat(on_port);
                beats_taken++;
            end
            // port is free once the current beat went in (or nothing was up)
            if (!start || !busy)
            begin
                if (!holding && pending_cmds.size() != 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    hold_off = next_cmd.gap;
                    holding = 1'b1;
                end
                if (holding && hold_off == 0)
                begin
                    on_port = next_cmd;
                    mode <= next_cmd.mode;
                    entry_index <= next_cmd.idx;
                    red <= next_cmd.r;
                    green <= next_cmd.g;
                    blue <= next_cmd.b;
                    start <= 1'b1;
                    holding = 1'b0;
                end
                else
                begin
                    if (holding)
                        hold_off--;
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: done is a one-cycle strobe, sampled at the edge that ends it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (awaited_matches.size() == 0)
                flag_mismatch($sformatf("unexpected result index %0d distance %0d",
                                        nearest_index, nearest_distance));
            else
            begin
                oldest = awaited_matches.pop_front();
                if (oldest.distance == 0)
                    exact_hits++;
                if (nearest_index !== oldest.index)
                    flag_mismatch($sformatf("nearest_index exp %0d got %0d",
                                            oldest.index, nearest_index));
                if (nearest_distance !== oldest.distance)
                    flag_mismatch($sformatf("nearest_distance exp %0d got %0d (index %0d)",
                                            oldest.distance, nearest_distance,
                                            oldest.index));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0]   pick;
        logic [23:0]  c;
        int unsigned  write_pct;

        beats_total = 0;
        beats_taken = 0;
        writes_taken = 0;
        queries_taken = 0;
        results_seen = 0;
        exact_hits = 0;
        mismatches = 0;
        calm_left = 0;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
            palette_shadow[i] = '0;
        for (int i = 0; i < 256; i++)
            plan_palette[i] = '0;

        // Directed: fresh palette is all black, so entry 0 wins every early query
        queue_cmd(MODE_QUERY, 8'd77, 8'h00, 8'h00, 8'h00);
        queue_cmd(MODE_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);    // largest distance
        queue_cmd(MODE_QUERY, 8'h00, 8'h80, 8'h01, 8'h7F);
        // move entry 0 away; black now ties over entries 1..255, lowest wins
        queue_cmd(MODE_WRITE, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(MODE_QUERY, 8'h12, 8'h00, 8'h00, 8'h00);
        queue_cmd(MODE_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00);
        queue_cmd(MODE_QUERY, 8'hAA, 8'hFF, 8'hFF, 8'hFE);
        // duplicate colors at 10 and 20: the lower one must be reported
        queue_cmd(MODE_WRITE, 8'd20, 8'd100, 8'd100, 8'd100);
        queue_cmd(MODE_WRITE, 8'd10, 8'd100, 8'd100, 8'd100);
        queue_cmd(MODE_QUERY, 8'd200, 8'd100, 8'd100, 8'd100);
        // equidistant distinct colors at 30 and 31, both nearer than any black entry
        for (int i = 1; i < 10; i++)
            queue_cmd(MODE_WRITE, 8'(i), 8'hFF, 8'h00, 8'hFF);
        queue_cmd(MODE_WRITE, 8'd30, 8'd200, 8'd10, 8'd10);
        queue_cmd(MODE_WRITE, 8'd31, 8'd10, 8'd200, 8'd10);
        queue_cmd(MODE_QUERY, 8'd31, 8'd105, 8'd105, 8'd10);
        // exact hit on the last entry
        queue_cmd(MODE_WRITE, 8'hFF, 8'h3C, 8'hC3, 8'h5A);
        queue_cmd(MODE_QUERY, 8'h00, 8'h3C, 8'hC3, 8'h5A);

        // Random: fill the palette first, then a write/query mix
        for (int n = 0; n < 1200; n++)
        begin
            write_pct = (n < 300) ? 90 : 65;
            if ($urandom_range(0, 99) < write_pct)
            begin
                case ($urandom_range(0, 9))
                    0:       pick = rail();
                    1:       pick = 8'($urandom_range(0, 7));
                    default: pick = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 9))
                    0:
                    begin
                        c = plan_palette[$urandom_range(0, 255)];
                        queue_cmd(MODE_WRITE, pick, c[23:16], c[15:8], c[7:0]);
                    end
                    1:       queue_cmd(MODE_WRITE, pick, rail(), rail(), rail());
                    default: queue_cmd(MODE_WRITE, pick, 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)));
                endcase
            end
            else
            begin
                pick = 8'($urandom_range(0, 255));
                c = plan_palette[$urandom_range(0, 255)];
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6:
                        queue_cmd(MODE_QUERY, pick, c[23:16], c[15:8], c[7:0]);
                    7, 8, 9, 10, 11:
                        queue_cmd(MODE_QUERY, pick, nudge(c[23:16]), nudge(c[15:8]),
                                  nudge(c[7:0]));
                    12, 13:
                        queue_cmd(MODE_QUERY, pick, rail(), rail(), rail());
                    default:
                        queue_cmd(MODE_QUERY, pick, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                endcase
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_taken < beats_total || awaited_matches.size() != 0)
            @(posedge clk);
        // a stray strobe after the last answer would still be caught here
        repeat (PALETTE_ENTRIES + 8) @(posedge clk);

        $display("Covered %0d palette writes and %0d nearest-color queries;",
                 writes_taken, queries_taken);
        $display("%0d answers checked, %0d of them exact color hits, %0d mismatches.",
                 results_seen, exact_hits, mismatches);
        if (mismatches == 0 && awaited_matches.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #25_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* nearest_palette_color_search_unit.f */
+incdir+design
design/npcs_pkg.sv
design/npcs_ctrl.sv
design/npcs_dp.sv
design/nearest_palette_color_search_unit.sv
design/npcs_checker.sv
tb/nearest_palette_color_search_unit_test.sv
